// File: rtl/ocs_pkg.sv
// shared constants, codes and types of the oscillator chain synthesis voice
package ocs_pkg;

    localparam int MAX_OPS_DEF         = 16;
    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam int CFG_W    = 5;
    localparam int SLOT_W   = 4;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 32;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic KIND_SINE  = 1'b0;
    localparam logic KIND_NOISE = 1'b1;

    localparam logic [1:0] COMBINE_ADD = 2'd0;
    localparam logic [1:0] COMBINE_MUL = 2'd1;
    localparam logic [1:0] COMBINE_PM  = 2'd2;

    // sine polynomial, q16
    localparam int SIN_A   = 102944;
    localparam int SIN_C   = 5222;
    localparam int SIN_B   = SIN_A + SIN_C - 65536;
    localparam int SIN_ONE = 65536;

    // radians q16.16 to phase turns
    localparam int PM_SCALE = 683565276;

    // noise source
    localparam logic [31:0] LFSR_MASK  = 32'hD000_0001;
    localparam logic [31:0] LFSR_RESET = 32'h0000_0001;
    localparam int NZ_MOD      = 20000;
    localparam int NZ_HALF     = 10000;
    localparam int NZ_DIV_BASE = 625;
    // floor(2^46 / 20000) and floor(2^40 / 625)
    localparam logic [31:0] NZ_RECIP_MOD = 32'd3518437208;
    localparam logic [31:0] NZ_RECIP_DIV = 32'd1759218604;

    typedef struct packed {
        logic        kind;
        logic [1:0]  combine;
        logic [31:0] step;
        logic [15:0] amp;
    } slot_entry_t;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if ((&v[49:31]) || !(|v[49:31])) begin
            r = v[31:0];
        end else if (v[49]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

// File: rtl/oscillator_chain_synth_unit.sv
// oscillator chain synthesis voice: slot tables, sequencer and shared multiplier
//
// Items enter on the s_ stream; tuser selects a slot load or a sample tick. A load item is
// written to the slot table and gives no result. A tick walks slots 0 to n-1, n being
// active_ops capped at MAX_OPS, with an extra step for each slot that phase-modulates or
// multiplies the running sum; every step of the walk goes through the one shared 33 x 33
// multiplier and the registered reads of the slot and phase memories. s_tready is low for
// the whole tick and the sample then waits in the output register while the next item is
// taken. Phases start at zero after reset through per-slot valid bits, so there is no
// clearing pass; a slot must be loaded before a tick evaluates it.
module oscillator_chain_synth_unit
    import ocs_pkg::*;
#(
    parameter int MAX_OPS         = MAX_OPS_DEF,
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata,      // active_ops
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,        // slot, source_kind, combine, phase_step,
                                                // amplitude, audible
    input  logic                s_tuser,        // mode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata         // sample
);

    localparam int IDX_W   = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
    localparam int CW      = (IDX_W > CFG_W) ? IDX_W : CFG_W;
    localparam int SW      = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int IW      = SINE_TABLE_BITS - 1;
    localparam int ZSH     = 18 - SINE_TABLE_BITS;
    localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);

    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_FETCH    = 5'd1;
    localparam logic [4:0] ST_DEC      = 5'd2;
    localparam logic [4:0] ST_PM_OFF   = 5'd3;
    localparam logic [4:0] ST_SIN_Z    = 5'd4;
    localparam logic [4:0] ST_SIN_Z2   = 5'd5;
    localparam logic [4:0] ST_SIN_C    = 5'd6;
    localparam logic [4:0] ST_SIN_T    = 5'd7;
    localparam logic [4:0] ST_SIN_T2   = 5'd8;
    localparam logic [4:0] ST_SIN_U    = 5'd9;
    localparam logic [4:0] ST_SIN_V    = 5'd10;
    localparam logic [4:0] ST_SIN_S    = 5'd11;
    localparam logic [4:0] ST_SIN_AMP  = 5'd12;
    localparam logic [4:0] ST_SIN_TERM = 5'd13;
    localparam logic [4:0] ST_N_M1     = 5'd14;
    localparam logic [4:0] ST_N_M2     = 5'd15;
    localparam logic [4:0] ST_N_M3     = 5'd16;
    localparam logic [4:0] ST_N_M4     = 5'd17;
    localparam logic [4:0] ST_N_M5     = 5'd18;
    localparam logic [4:0] ST_N_M6     = 5'd19;
    localparam logic [4:0] ST_N_M7     = 5'd20;
    localparam logic [4:0] ST_N_M8     = 5'd21;
    localparam logic [4:0] ST_N_M9     = 5'd22;
    localparam logic [4:0] ST_N_M10    = 5'd23;
    localparam logic [4:0] ST_COMB     = 5'd24;
    localparam logic [4:0] ST_MUL_RES  = 5'd25;
    localparam logic [4:0] ST_NEXT     = 5'd26;
    localparam logic [4:0] ST_DONE     = 5'd27;

    // input fields
    logic [SLOT_W-1:0] in_slot;
    logic              in_kind;
    logic [1:0]        in_combine;
    logic [31:0]       in_step;
    logic [15:0]       in_amp;
    logic              in_audible;

    assign in_slot    = s_tdata[3:0];
    assign in_kind    = s_tdata[4];
    assign in_combine = s_tdata[6:5];
    assign in_step    = s_tdata[38:7];
    assign in_amp     = s_tdata[54:39];
    assign in_audible = s_tdata[55];

    // control state
    logic [4:0]         state_reg, state_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [CFG_W-1:0]   active_ops_reg;
    logic [31:0]        lfsr_reg, lfsr_next;
    logic [MAX_OPS-1:0] ph_vld_reg;
    logic               ph_vld_rd_reg;

    // datapath
    logic [CW-1:0]        op_idx_reg, op_idx_next;
    logic                 audible_reg, audible_next;
    logic signed [31:0]   sum_reg, sum_next;
    logic [31:0]          ph_reg, ph_next;
    logic [16:0]          z_reg, z_next;
    logic [1:0]           quad_reg, quad_next;
    logic [16:0]          z2_reg, z2_next;
    logic [15:0]          t_reg, t_next;
    logic [16:0]          u_reg, u_next;
    logic signed [17:0]   s_reg, s_next;
    logic signed [31:0]   term_reg, term_next;
    logic [15:0]          r0_reg, r0_next;
    logic                 rneg_reg, rneg_next;
    logic [13:0]          rmag_reg, rmag_next;
    logic [29:0]          p_reg, p_next;
    logic [20:0]          q0_reg, q0_next;
    logic [10:0]          b0_reg, b0_next;
    logic [M_DATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic signed [65:0]   prod_reg;
    logic signed [32:0]   mul_a, mul_b;

    // memories
    slot_entry_t tbl_mem [MAX_OPS];
    slot_entry_t tbl_rd_reg;
    logic [31:0] ph_mem [MAX_OPS];
    logic [31:0] ph_rd_reg;

    logic [SW-1:0]    slot_ext;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic             in_accept;
    logic             tbl_we;
    logic             ph_we;
    logic [31:0]      phase_q;
    logic [31:0]      ph_wr_data;
    logic [CFG_W-1:0] n_ops;
    slot_entry_t      in_entry;

    // helper logic
    logic [SINE_TABLE_BITS-1:0] sin_k;
    logic [1:0]                 sin_quad;
    logic [SINE_TABLE_BITS-3:0] sin_rem;
    logic [IW-1:0]              sin_idx;
    logic [16:0]                sin_v;
    logic [16:0]                sin_vcap;
    logic [31:0]                lfsr_step;
    logic [14:0]                nz_r1;
    logic [3:0]                 nz_c;
    logic [24:0]                nz_mag;

    assign in_accept = s_tvalid && s_tready;
    assign slot_ext  = SW'(in_slot);
    assign wr_addr   = slot_ext[IDX_W-1:0];
    assign rd_addr   = op_idx_reg[IDX_W-1:0];
    assign tbl_we    = in_accept && (s_tuser == MODE_LOAD) && (32'(in_slot) < MAX_OPS);
    assign ph_we     = (state_reg == ST_SIN_TERM);
    assign phase_q   = ph_vld_rd_reg ? ph_rd_reg : '0;
    assign ph_wr_data = phase_q + tbl_rd_reg.step;
    assign n_ops     = (32'(active_ops_reg) > MAX_OPS) ? CFG_W'(MAX_OPS) : active_ops_reg;

    assign in_entry.kind    = in_kind;
    assign in_entry.combine = in_combine;
    assign in_entry.step    = in_step;
    assign in_entry.amp     = in_amp;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        sin_k    = ph_reg[31 -: SINE_TABLE_BITS];
        sin_quad = sin_k[SINE_TABLE_BITS-1 -: 2];
        sin_rem  = sin_k[SINE_TABLE_BITS-3:0];
        sin_idx  = sin_quad[0] ? (IW'(QUARTER) - IW'(sin_rem)) : IW'(sin_rem);
        sin_v    = prod_reg[32:16];
        sin_vcap = (sin_v > 17'(SIN_ONE)) ? 17'(SIN_ONE) : sin_v;
        lfsr_step = {1'b0, lfsr_reg[31:1]} ^ (lfsr_reg[0] ? LFSR_MASK : 32'd0);
        nz_r1 = (r0_reg >= 16'(NZ_MOD)) ? 15'(r0_reg - 16'(NZ_MOD)) : 15'(r0_reg);
        nz_c = '0;
        for (int k = 1; k < 16; k++) begin
            if ({b0_reg, 4'b0000} >= 15'(NZ_DIV_BASE * k)) begin
                nz_c = 4'(k);
            end
        end
        nz_mag = {q0_reg, nz_c};
    end

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        lfsr_next     = lfsr_reg;
        op_idx_next   = op_idx_reg;
        audible_next  = audible_reg;
        sum_next      = sum_reg;
        ph_next       = ph_reg;
        z_next        = z_reg;
        quad_next     = quad_reg;
        z2_next       = z2_reg;
        t_next        = t_reg;
        u_next        = u_reg;
        s_next        = s_reg;
        term_next     = term_reg;
        r0_next       = r0_reg;
        rneg_next     = rneg_reg;
        rmag_next     = rmag_reg;
        p_next        = p_reg;
        q0_next       = q0_reg;
        b0_next       = b0_reg;
        mul_a         = '0;
        mul_b         = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept && (s_tuser == MODE_TICK)) begin
                    op_idx_next  = '0;
                    sum_next     = '0;
                    audible_next = in_audible;
                    state_next   = (n_ops == '0) ? ST_DONE : ST_FETCH;
                end
            end
            ST_FETCH: begin
                state_next = ST_DEC;
            end
            ST_DEC: begin
                if (tbl_rd_reg.kind == KIND_SINE) begin
                    if (tbl_rd_reg.combine >= COMBINE_PM) begin
                        mul_a      = 33'(sum_reg);
                        mul_b      = 33'(PM_SCALE);
                        state_next = ST_PM_OFF;
                    end else begin
                        ph_next    = phase_q;
                        state_next = ST_SIN_Z;
                    end
                end else begin
                    lfsr_next  = lfsr_step;
                    state_next = ST_N_M1;
                end
            end
            ST_PM_OFF: begin
                ph_next    = phase_q + prod_reg[47:16];
                state_next = ST_SIN_Z;
            end
            ST_SIN_Z: begin
                z_next     = {sin_idx, {ZSH{1'b0}}};
                quad_next  = sin_quad;
                state_next = ST_SIN_Z2;
            end
            ST_SIN_Z2: begin
                mul_a      = 33'(z_reg);
                mul_b      = 33'(z_reg);
                state_next = ST_SIN_C;
            end
            ST_SIN_C: begin
                z2_next    = prod_reg[32:16];
                mul_a      = 33'(prod_reg[32:16]);
                mul_b      = 33'(SIN_C);
                state_next = ST_SIN_T;
            end
            ST_SIN_T: begin
                t_next     = 16'(17'(SIN_B) - prod_reg[32:16]);
                state_next = ST_SIN_T2;
            end
            ST_SIN_T2: begin
                mul_a      = 33'(z2_reg);
                mul_b      = 33'(t_reg);
                state_next = ST_SIN_U;
            end
            ST_SIN_U: begin
                u_next     = 17'(SIN_A) - prod_reg[32:16];
                state_next = ST_SIN_V;
            end
            ST_SIN_V: begin
                mul_a      = 33'(z_reg);
                mul_b      = 33'(u_reg);
                state_next = ST_SIN_S;
            end
            ST_SIN_S: begin
                s_next     = quad_reg[1] ? -$signed({1'b0, sin_vcap}) : $signed({1'b0, sin_vcap});
                state_next = ST_SIN_AMP;
            end
            ST_SIN_AMP: begin
                mul_a      = 33'(s_reg);
                mul_b      = 33'(tbl_rd_reg.amp);
                state_next = ST_SIN_TERM;
            end
            ST_SIN_TERM: begin
                term_next  = prod_reg[39:8];
                state_next = ST_COMB;
            end
            ST_N_M1: begin
                mul_a      = 33'(lfsr_reg);
                mul_b      = 33'(NZ_RECIP_MOD);
                state_next = ST_N_M2;
            end
            ST_N_M2: begin
                mul_a      = 33'(prod_reg[63:46]);
                mul_b      = 33'(NZ_MOD);
                state_next = ST_N_M3;
            end
            ST_N_M3: begin
                r0_next    = 16'(lfsr_reg - prod_reg[31:0]);
                state_next = ST_N_M4;
            end
            ST_N_M4: begin
                rneg_next  = (nz_r1 < 15'(NZ_HALF));
                rmag_next  = (nz_r1 < 15'(NZ_HALF)) ? 14'(15'(NZ_HALF) - nz_r1)
                                                     : 14'(nz_r1 - 15'(NZ_HALF));
                state_next = ST_N_M5;
            end
            ST_N_M5: begin
                mul_a      = 33'(rmag_reg);
                mul_b      = 33'(tbl_rd_reg.amp);
                state_next = ST_N_M6;
            end
            ST_N_M6: begin
                p_next     = prod_reg[29:0];
                mul_a      = 33'(prod_reg[29:0]);
                mul_b      = 33'(NZ_RECIP_DIV);
                state_next = ST_N_M7;
            end
            ST_N_M7: begin
                q0_next    = prod_reg[60:40];
                mul_a      = 33'(prod_reg[60:40]);
                mul_b      = 33'(NZ_DIV_BASE);
                state_next = ST_N_M8;
            end
            ST_N_M8: begin
                b0_next    = 11'(p_reg - prod_reg[29:0]);
                state_next = ST_N_M9;
            end
            ST_N_M9: begin
                if (b0_reg >= 11'(NZ_DIV_BASE)) begin
                    q0_next = q0_reg + 21'd1;
                    b0_next = b0_reg - 11'(NZ_DIV_BASE);
                end
                state_next = ST_N_M10;
            end
            ST_N_M10: begin
                term_next  = rneg_reg ? -$signed(32'(nz_mag)) : $signed(32'(nz_mag));
                state_next = ST_COMB;
            end
            ST_COMB: begin
                if ((tbl_rd_reg.kind == KIND_SINE) && (tbl_rd_reg.combine >= COMBINE_PM)) begin
                    sum_next   = term_reg;
                    state_next = ST_NEXT;
                end else if (tbl_rd_reg.combine == COMBINE_ADD) begin
                    sum_next   = sat32(50'(sum_reg) + 50'(term_reg));
                    state_next = ST_NEXT;
                end else begin
                    mul_a      = 33'(sum_reg);
                    mul_b      = 33'(term_reg);
                    state_next = ST_MUL_RES;
                end
            end
            ST_MUL_RES: begin
                sum_next   = sat32(prod_reg[65:16]);
                state_next = ST_NEXT;
            end
            ST_NEXT: begin
                if ((op_idx_reg + CW'(1)) == CW'(n_ops)) begin
                    state_next = ST_DONE;
                end else begin
                    op_idx_next = op_idx_reg + CW'(1);
                    state_next  = ST_FETCH;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = audible_reg ? sum_reg : '0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_tvalid_reg   <= 1'b0;
            active_ops_reg <= '0;
            lfsr_reg       <= LFSR_RESET;
            ph_vld_reg     <= '0;
            ph_vld_rd_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            lfsr_reg     <= lfsr_next;
            if (cfg_we) begin
                active_ops_reg <= cfg_wdata;
            end
            if (ph_we) begin
                ph_vld_reg[rd_addr] <= 1'b1;
            end
            if (state_reg == ST_FETCH) begin
                ph_vld_rd_reg <= ph_vld_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_idx_reg  <= op_idx_next;
        audible_reg <= audible_next;
        sum_reg     <= sum_next;
        ph_reg      <= ph_next;
        z_reg       <= z_next;
        quad_reg    <= quad_next;
        z2_reg      <= z2_next;
        t_reg       <= t_next;
        u_reg       <= u_next;
        s_reg       <= s_next;
        term_reg    <= term_next;
        r0_reg      <= r0_next;
        rneg_reg    <= rneg_next;
        rmag_reg    <= rmag_next;
        p_reg       <= p_next;
        q0_reg      <= q0_next;
        b0_reg      <= b0_next;
        m_tdata_reg <= m_tdata_next;
        prod_reg    <= mul_a * mul_b;
    end

    // slot table, undefined until loaded
    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[wr_addr] <= in_entry;
        end
        if (state_reg == ST_FETCH) begin
            tbl_rd_reg <= tbl_mem[rd_addr];
        end
    end

    // phase accumulators, zero until first written
    always_ff @(posedge aclk) begin
        if (ph_we) begin
            ph_mem[rd_addr] <= ph_wr_data;
        end
        if (state_reg == ST_FETCH) begin
            ph_rd_reg <= ph_mem[rd_addr];
        end
    end

endmodule

// File: rtl/ocs_checker.sv
// port-level checks on the oscillator chain synthesis voice, bound to the top level
module ocs_checker
    import ocs_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // a tick item holds off the next item
    a_tick_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == MODE_TICK)) |=> !s_tready)
        else $error("ready stayed high after a tick item");

    // a load item leaves the block ready
    a_load_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == MODE_LOAD)) |=> s_tready)
        else $error("ready dropped after a load item");

    // a new sample only comes out of a tick in progress
    a_sample_from_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("sample appeared while idle");

    // stalled sample holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled sample changed");

endmodule

bind oscillator_chain_synth_unit ocs_checker u_ocs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
